>>> hdl/qrpm_pkg.sv
// ----------------------------------------------------------------------------
// qrpm_pkg - shared types and constants of the query/response pair matcher
// Entry layouts of the pair store and the waiting store, the result item,
// and the sequencer-to-result-stage control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package qrpm_pkg;

  localparam int unsigned OUT_DEPTH_DEF  = 32;
  localparam int unsigned WAIT_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 48;
  localparam int unsigned NCNT_W         = 6;
  localparam int unsigned TIME_W         = 63;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned TC_W           = 32;
  localparam int unsigned HANDLE_W       = 16;
  localparam int unsigned TMO_W          = 32;

  // configuration register indexes
  localparam logic REG_QUERY_TIMEOUT = 1'b0;
  localparam logic REG_SKEW_TIMEOUT  = 1'b1;

  localparam logic [TMO_W-1:0] QUERY_TIMEOUT_RST = 32'd5000000;
  localparam logic [TMO_W-1:0] SKEW_TIMEOUT_RST  = 32'd10;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    name;
    logic [TC_W-1:0]     tc;
    logic [TIME_W-1:0]   time_us;
    logic [HANDLE_W-1:0] qh;
    logic [HANDLE_W-1:0] rh;
    logic                has_q;
    logic                has_r;
    logic                done;
    logic                question;
  } pair_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    name;
    logic [TC_W-1:0]     tc;
    logic [TIME_W-1:0]   time_us;
    logic [HANDLE_W-1:0] handle;
    logic                has_question;
  } wait_entry_t;

  typedef struct packed {
    logic                status;
    logic                has_q;
    logic [HANDLE_W-1:0] qh;
    logic                has_r;
    logic [HANDLE_W-1:0] rh;
    logic [TIME_W-1:0]   time_us;
  } result_t;

  typedef struct packed {
    logic    start;
    logic    emit;
    logic    fin;
    result_t res;
  } emit_req_t;

  typedef struct packed {
    logic busy;
    logic capped;
  } emit_stat_t;

  function automatic result_t pair_result(pair_entry_t e);
    result_t r;
    r.status  = 1'b0;
    r.has_q   = e.has_q;
    r.qh      = e.has_q ? e.qh : '0;
    r.has_r   = e.has_r;
    r.rh      = e.has_r ? e.rh : '0;
    r.time_us = e.time_us;
    return r;
  endfunction

  function automatic result_t drop_result(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] t);
    result_t r;
    r.status  = 1'b1;
    r.has_q   = 1'b0;
    r.qh      = h;
    r.has_r   = 1'b0;
    r.rh      = '0;
    r.time_us = t;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/query_response_pair_matcher.sv
// ----------------------------------------------------------------------------
// query_response_pair_matcher - DNS query/response pairing engine
// Pairs responses with the oldest open query of the same flow and question,
// parks early responses, times out queries and parked responses, and sends
// finished pairs in arrival order.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid/in_ready, in_* message item  | input
//  out     | out_valid/out_ready, out_* result     | output
//  cfg     | cfg_valid/cfg_ready, cfg_index, data  | input
//
//  An item's run time varies: the sequencer reads and then examines each
//  pair store entry visited in the timeout scan and the response search,
//  each waiting entry in each compaction pass and each result drained,
//  plus dispatch and finish, since each memory has a single read port.
//  in_ready is high only while the sequencer is idle and out of reset. A
//  stalled out channel holds the sequencer at its next result.
//  Reset is synchronous and empties both stores; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module query_response_pair_matcher
  import qrpm_pkg::*;
#(
  parameter int unsigned OUT_DEPTH  = OUT_DEPTH_DEF,
  parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic                in_is_query,
  input  wire logic [KEY_W-1:0]    in_flow_key,
  input  wire logic                in_has_question,
  input  wire logic [KEY_W-1:0]    in_name_digest,
  input  wire logic [15:0]         in_question_type,
  input  wire logic [15:0]         in_question_class,
  input  wire logic [TIME_W-1:0]   in_timestamp_us,
  input  wire logic [HANDLE_W-1:0] in_message_handle,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_status,
  output logic                     out_pair_has_query,
  output logic [HANDLE_W-1:0]      out_query_handle,
  output logic                     out_pair_has_response,
  output logic [HANDLE_W-1:0]      out_response_handle,
  output logic [TIME_W-1:0]        out_pair_time_us,
  output logic                     out_last,

  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [TMO_W-1:0]    cfg_data
);

  localparam int unsigned AW  = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TO_RD = 5'd1;   // query timeout scan
  localparam logic [4:0] S_TO_EX = 5'd2;
  localparam logic [4:0] S_DR_RD = 5'd3;   // drain finished pairs at front
  localparam logic [4:0] S_DR_EX = 5'd4;
  localparam logic [4:0] S_SK_RD = 5'd5;   // skew timeout compaction
  localparam logic [4:0] S_SK_EX = 5'd6;
  localparam logic [4:0] S_QP    = 5'd7;   // push query
  localparam logic [4:0] S_MT_RD = 5'd8;   // waiting responses vs new query
  localparam logic [4:0] S_MT_EX = 5'd9;
  localparam logic [4:0] S_RS_RD = 5'd10;  // response search
  localparam logic [4:0] S_RS_EX = 5'd11;
  localparam logic [4:0] S_RS_NM = 5'd12;  // park or drop unmatched response
  localparam logic [4:0] S_FP_RD = 5'd13;  // flush pairs
  localparam logic [4:0] S_FP_EX = 5'd14;
  localparam logic [4:0] S_FW_RD = 5'd15;  // flush waiting responses
  localparam logic [4:0] S_FW_EX = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  logic [4:0]          state_r, state_nxt;
  logic                drain2_r, drain2_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [WCW-1:0]      wcnt_r, wcnt_nxt;
  logic [WCW-1:0]      rd_r, rd_nxt;
  logic [WCW-1:0]      wr_r, wr_nxt;
  logic                found_r, found_nxt;
  logic [TMO_W-1:0]    qto_r, sto_r;

  // latched message
  logic                isq_r;
  logic [KEY_W-1:0]    key_r;
  logic                hasq_r;
  logic [KEY_W-1:0]    name_r;
  logic [TC_W-1:0]     tc_r;
  logic [TIME_W-1:0]   now_r;
  logic [HANDLE_W-1:0] h_r;

  // memories and shared units
  logic          pm_we, pm_re;
  logic [AW-1:0] pm_waddr, pm_raddr;
  pair_entry_t   pm_wdata, pm_q;
  logic          wm_we, wm_re;
  logic [WAW-1:0] wm_waddr, wm_raddr;
  wait_entry_t   wm_wdata, wm_q;
  logic [TIME_W-1:0] age_time;
  logic [TMO_W-1:0]  age_tmo;
  logic          age_expired, age_stale;
  emit_req_t     req;
  emit_stat_t    stat;
  result_t       out_res;
  logic          stall;

  pair_entry_t   qent;
  pair_entry_t   lone;
  wait_entry_t   went;
  pair_entry_t   closed;
  logic          hit_mt, hit_rs;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(OUT_DEPTH)) begin
      s = s - (CW+1)'(OUT_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // hold both channels off while reset is applied
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;

  // entry images built from the latched message
  always_comb begin
    qent.key      = key_r;
    qent.name     = hasq_r ? name_r : '0;
    qent.tc       = hasq_r ? tc_r : '0;
    qent.time_us  = now_r;
    qent.qh       = h_r;
    qent.rh       = '0;
    qent.has_q    = 1'b1;
    qent.has_r    = 1'b0;
    qent.done     = 1'b0;
    qent.question = hasq_r;

    lone.key      = '0;
    lone.name     = '0;
    lone.tc       = '0;
    lone.time_us  = wm_q.time_us;
    lone.qh       = '0;
    lone.rh       = wm_q.handle;
    lone.has_q    = 1'b0;
    lone.has_r    = 1'b1;
    lone.done     = 1'b1;
    lone.question = 1'b0;

    went.key          = key_r;
    went.name         = name_r;
    went.tc           = tc_r;
    went.time_us      = now_r;
    went.handle       = h_r;
    went.has_question = hasq_r;

    closed       = pm_q;
    closed.rh    = h_r;
    closed.has_r = 1'b1;
    closed.done  = 1'b1;

    // a parked response can only answer the query just pushed
    hit_mt = !found_r && (wm_q.key == key_r) &&
             (!wm_q.has_question ||
              (hasq_r && (wm_q.name == name_r) && (wm_q.tc == tc_r)));
    hit_rs = !pm_q.done && (pm_q.key == key_r) &&
             (!hasq_r || (pm_q.question && (pm_q.name == name_r) && (pm_q.tc == tc_r)));
  end

  assign stall = req.emit && !stat.capped && stat.busy;

  always_comb begin
    state_nxt  = state_r;
    drain2_nxt = drain2_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    tail_nxt   = tail_r;
    wcnt_nxt   = wcnt_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    found_nxt  = found_r;
    pm_we      = 1'b0;
    pm_re      = 1'b0;
    pm_waddr   = '0;
    pm_raddr   = '0;
    pm_wdata   = pm_q;
    wm_we      = 1'b0;
    wm_re      = 1'b0;
    wm_waddr   = '0;
    wm_raddr   = '0;
    wm_wdata   = wm_q;
    age_time   = pm_q.time_us;
    age_tmo    = qto_r;
    req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req.start  = 1'b1;
          i_nxt      = '0;
          rd_nxt     = '0;
          drain2_nxt = 1'b0;
          state_nxt  = in_cmd ? S_FP_RD : S_TO_RD;
        end
      end

      S_TO_RD: begin
        if (i_r >= cnt_r) begin
          state_nxt = S_DR_RD;
        end else begin
          pm_re     = 1'b1;
          pm_raddr  = wrap_add(head_r, i_r);
          state_nxt = S_TO_EX;
        end
      end

      S_TO_EX: begin
        if (pm_q.done) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_TO_RD;
        end else if (!age_expired) begin
          state_nxt = S_DR_RD;
        end else begin
          pm_we         = 1'b1;
          pm_waddr      = wrap_add(head_r, i_r);
          pm_wdata.done = 1'b1;
          i_nxt         = i_r + CW'(1);
          state_nxt     = S_TO_RD;
        end
      end

      S_DR_RD: begin
        if ((cnt_r == '0) || stat.capped) begin
          if (drain2_r) begin
            state_nxt = S_FIN;
          end else begin
            rd_nxt    = '0;
            wr_nxt    = '0;
            state_nxt = S_SK_RD;
          end
        end else begin
          pm_re     = 1'b1;
          pm_raddr  = head_r;
          state_nxt = S_DR_EX;
        end
      end

      S_DR_EX: begin
        if (!pm_q.done) begin
          if (drain2_r) begin
            state_nxt = S_FIN;
          end else begin
            rd_nxt    = '0;
            wr_nxt    = '0;
            state_nxt = S_SK_RD;
          end
        end else begin
          req.emit = 1'b1;
          req.res  = pair_result(pm_q);
          if (!stall) begin
            head_nxt  = wrap_add(head_r, CW'(1));
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DR_RD;
          end
        end
      end

      S_SK_RD: begin
        if (rd_r >= wcnt_r) begin
          wcnt_nxt  = wr_r;
          i_nxt     = '0;
          state_nxt = isq_r ? S_QP : S_RS_RD;
        end else begin
          wm_re     = 1'b1;
          wm_raddr  = rd_r[WAW-1:0];
          state_nxt = S_SK_EX;
        end
      end

      S_SK_EX: begin
        age_time = wm_q.time_us;
        age_tmo  = sto_r;
        if (age_stale) begin
          if (cnt_r >= CW'(OUT_DEPTH)) begin
            req.emit = 1'b1;
            req.res  = drop_result('0, wm_q.time_us);
          end else begin
            pm_we    = 1'b1;
            pm_waddr = wrap_add(head_r, cnt_r);
            pm_wdata = lone;
            cnt_nxt  = cnt_r + CW'(1);
          end
          if (!stall) begin
            rd_nxt    = rd_r + WCW'(1);
            state_nxt = S_SK_RD;
          end
        end else begin
          wm_we     = 1'b1;
          wm_waddr  = wr_r[WAW-1:0];
          wr_nxt    = wr_r + WCW'(1);
          rd_nxt    = rd_r + WCW'(1);
          state_nxt = S_SK_RD;
        end
      end

      S_QP: begin
        if (cnt_r >= CW'(OUT_DEPTH)) begin
          req.emit = 1'b1;
          req.res  = drop_result(h_r, now_r);
          if (!stall) begin
            drain2_nxt = 1'b1;
            state_nxt  = S_DR_RD;
          end
        end else begin
          pm_we     = 1'b1;
          pm_waddr  = wrap_add(head_r, cnt_r);
          pm_wdata  = qent;
          tail_nxt  = wrap_add(head_r, cnt_r);
          cnt_nxt   = cnt_r + CW'(1);
          rd_nxt    = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
          state_nxt = S_MT_RD;
        end
      end

      S_MT_RD: begin
        if (rd_r >= wcnt_r) begin
          wcnt_nxt   = wr_r;
          drain2_nxt = 1'b1;
          state_nxt  = S_DR_RD;
        end else begin
          wm_re     = 1'b1;
          wm_raddr  = rd_r[WAW-1:0];
          state_nxt = S_MT_EX;
        end
      end

      S_MT_EX: begin
        if (hit_mt) begin
          pm_we          = 1'b1;
          pm_waddr       = tail_r;
          pm_wdata       = qent;
          pm_wdata.rh    = wm_q.handle;
          pm_wdata.has_r = 1'b1;
          pm_wdata.done  = 1'b1;
          found_nxt      = 1'b1;
        end else begin
          wm_we    = 1'b1;
          wm_waddr = wr_r[WAW-1:0];
          wr_nxt   = wr_r + WCW'(1);
        end
        rd_nxt    = rd_r + WCW'(1);
        state_nxt = S_MT_RD;
      end

      S_RS_RD: begin
        if (i_r >= cnt_r) begin
          state_nxt = S_RS_NM;
        end else begin
          pm_re     = 1'b1;
          pm_raddr  = wrap_add(head_r, i_r);
          state_nxt = S_RS_EX;
        end
      end

      S_RS_EX: begin
        if (hit_rs) begin
          pm_we      = 1'b1;
          pm_waddr   = wrap_add(head_r, i_r);
          pm_wdata   = closed;
          drain2_nxt = 1'b1;
          state_nxt  = S_DR_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_RS_RD;
        end
      end

      S_RS_NM: begin
        if (wcnt_r < WCW'(WAIT_DEPTH)) begin
          wm_we      = 1'b1;
          wm_waddr   = wcnt_r[WAW-1:0];
          wm_wdata   = went;
          wcnt_nxt   = wcnt_r + WCW'(1);
          drain2_nxt = 1'b1;
          state_nxt  = S_DR_RD;
        end else begin
          req.emit = 1'b1;
          req.res  = drop_result(h_r, now_r);
          if (!stall) begin
            drain2_nxt = 1'b1;
            state_nxt  = S_DR_RD;
          end
        end
      end

      S_FP_RD: begin
        if (i_r >= cnt_r) begin
          rd_nxt    = '0;
          state_nxt = S_FW_RD;
        end else begin
          pm_re     = 1'b1;
          pm_raddr  = wrap_add(head_r, i_r);
          state_nxt = S_FP_EX;
        end
      end

      S_FP_EX: begin
        req.emit = 1'b1;
        req.res  = pair_result(pm_q);
        if (!stall) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_FP_RD;
        end
      end

      S_FW_RD: begin
        if (rd_r >= wcnt_r) begin
          cnt_nxt   = '0;
          wcnt_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          wm_re     = 1'b1;
          wm_raddr  = rd_r[WAW-1:0];
          state_nxt = S_FW_EX;
        end
      end

      S_FW_EX: begin
        req.emit          = 1'b1;
        req.res.status    = 1'b0;
        req.res.has_q     = 1'b0;
        req.res.qh        = '0;
        req.res.has_r     = 1'b1;
        req.res.rh        = wm_q.handle;
        req.res.time_us   = wm_q.time_us;
        if (!stall) begin
          rd_nxt    = rd_r + WCW'(1);
          state_nxt = S_FW_RD;
        end
      end

      S_FIN: begin
        req.fin = 1'b1;
        if (!stat.busy) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      drain2_r <= 1'b0;
      head_r   <= '0;
      cnt_r    <= '0;
      i_r      <= '0;
      tail_r   <= '0;
      wcnt_r   <= '0;
      rd_r     <= '0;
      wr_r     <= '0;
      found_r  <= 1'b0;
      qto_r    <= QUERY_TIMEOUT_RST;
      sto_r    <= SKEW_TIMEOUT_RST;
    end else begin
      state_r  <= state_nxt;
      drain2_r <= drain2_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      i_r      <= i_nxt;
      tail_r   <= tail_nxt;
      wcnt_r   <= wcnt_nxt;
      rd_r     <= rd_nxt;
      wr_r     <= wr_nxt;
      found_r  <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_QUERY_TIMEOUT: qto_r <= cfg_data;
          REG_SKEW_TIMEOUT:  sto_r <= cfg_data;
          default:           qto_r <= qto_r;
        endcase
      end
    end
  end

  // hold the accepted message for the whole item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      isq_r  <= in_is_query;
      key_r  <= in_flow_key;
      hasq_r <= in_has_question;
      name_r <= in_name_digest;
      tc_r   <= {in_question_type, in_question_class};
      now_r  <= in_timestamp_us;
      h_r    <= in_message_handle;
    end
  end

  qrpm_pair_store #(
    .DEPTH (OUT_DEPTH),
    .AW    (AW)
  ) u_pair_store (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .re    (pm_re),
    .raddr (pm_raddr),
    .rdata (pm_q)
  );

  qrpm_wait_store #(
    .DEPTH (WAIT_DEPTH),
    .AW    (WAW)
  ) u_wait_store (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .re    (wm_re),
    .raddr (wm_raddr),
    .rdata (wm_q)
  );

  qrpm_age_unit u_age (
    .time_us (age_time),
    .tmo     (age_tmo),
    .now_us  (now_r),
    .expired (age_expired),
    .stale   (age_stale)
  );

  qrpm_result_stage u_result (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res),
    .out_last_bit (out_last)
  );

  assign out_status            = out_res.status;
  assign out_pair_has_query    = out_res.has_q;
  assign out_query_handle      = out_res.qh;
  assign out_pair_has_response = out_res.has_r;
  assign out_response_handle   = out_res.rh;
  assign out_pair_time_us      = out_res.time_us;

endmodule

`default_nettype wire

>>> hdl/qrpm_pair_store.sv
// ----------------------------------------------------------------------------
// qrpm_pair_store - pair queue memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrpm_pair_store
  import qrpm_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_DEPTH_DEF,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pair_entry_t   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output pair_entry_t        rdata
);

  pair_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/qrpm_wait_store.sv
// ----------------------------------------------------------------------------
// qrpm_wait_store - waiting response memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrpm_wait_store
  import qrpm_pkg::*;
#(
  parameter int unsigned DEPTH = WAIT_DEPTH_DEF,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire wait_entry_t   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output wait_entry_t        rdata
);

  wait_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/qrpm_age_unit.sv
// ----------------------------------------------------------------------------
// qrpm_age_unit - shared timestamp age comparator
// Adds a timeout to a stored time and compares the sum against now.
// ----------------------------------------------------------------------------
`default_nettype none

module qrpm_age_unit
  import qrpm_pkg::*;
(
  input  wire logic [TIME_W-1:0] time_us,
  input  wire logic [TMO_W-1:0]  tmo,
  input  wire logic [TIME_W-1:0] now_us,
  output logic                   expired,
  output logic                   stale
);

  logic [TIME_W:0] sum;
  logic [TIME_W:0] now_x;

  assign sum     = {1'b0, time_us} + (TIME_W+1)'(tmo);
  assign now_x   = {1'b0, now_us};
  assign expired = (sum <= now_x);
  assign stale   = (sum < now_x);

endmodule

`default_nettype wire

>>> hdl/qrpm_result_stage.sv
// ----------------------------------------------------------------------------
// qrpm_result_stage - result staging and output register
// Hold the newest result back until the next one or the end of the item
// shows whether it is the last; cap results per item.
// ----------------------------------------------------------------------------
`default_nettype none

module qrpm_result_stage
  import qrpm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire emit_req_t           req,
  output emit_stat_t               stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output result_t                  out_res,
  output logic                     out_last_bit
);

  logic               pend_v_r, pend_v_nxt;
  result_t            pend_r, pend_nxt;
  logic               outv_r, outv_nxt;
  result_t            outd_r, outd_nxt;
  logic               last_r, last_nxt;
  logic [NCNT_W-1:0]  n_r, n_nxt;
  logic               busy;
  logic               capped;

  assign busy        = pend_v_r && outv_r;
  assign capped      = (n_r >= NCNT_W'(MAX_RESULTS));
  assign stat        = {busy, capped};

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    outv_nxt   = outv_r && !out_ready;
    outd_nxt   = outd_r;
    last_nxt   = last_r;
    n_nxt      = n_r;
    if (req.start) begin
      n_nxt = '0;
    end
    if (req.emit && !capped && !busy) begin
      if (pend_v_r) begin
        outd_nxt = pend_r;
        last_nxt = 1'b0;
        outv_nxt = 1'b1;
      end
      pend_nxt   = req.res;
      pend_v_nxt = 1'b1;
      n_nxt      = n_r + NCNT_W'(1);
    end
    if (req.fin && !busy && pend_v_r) begin
      outd_nxt   = pend_r;
      last_nxt   = 1'b1;
      outv_nxt   = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      outv_r   <= 1'b0;
      n_r      <= '0;
    end else begin
      pend_v_r <= pend_v_nxt;
      outv_r   <= outv_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    outd_r <= outd_nxt;
    last_r <= last_nxt;
  end

  assign out_valid    = outv_r;
  assign out_res      = outd_r;
  assign out_last_bit = last_r;

endmodule

`default_nettype wire
